@@ hdl/istrc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// istrc_pkg
// Shared types, codes and constants of the implicit super-twisting rate
// controller.
// ----------------------------------------------------------------------------
package istrc_pkg;

    localparam int AXES_DEF       = 3;
    localparam int DATA_WIDTH_DEF = 32;

    // configuration port
    localparam int NCFG       = 3;
    localparam int GAIN_REG_W = 63;
    localparam int APB_DW     = 64;
    localparam int ADDR_W     = 5;

    // gain field layout, unsigned Q11.10
    localparam int GAIN_W = 21;
    localparam int L1_LSB = 0;
    localparam int L2_LSB = 21;
    localparam int G_LSB  = 42;

    // item fields
    localparam int IN_W  = 32;
    localparam int H_W   = 24;
    localparam int OUT_W = 32;
    localparam int XI_W  = 18;

    // arithmetic units
    localparam int DVD_W   = 64;
    localparam int DVS_W   = 43;
    localparam int SQ_IN_W = 56;
    localparam int SQ_W    = SQ_IN_W / 2;
    localparam int ONE_Q16 = 65536;

    typedef logic [GAIN_REG_W-1:0] t_gain;

    typedef enum logic [1:0] {
        REG_AXIS0_GAINS = 2'd0,
        REG_AXIS1_GAINS = 2'd1,
        REG_AXIS2_GAINS = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_SET    = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_IGNORE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_INVALID_AXIS = 3'd1,
        ST_NOT_CONF     = 3'd2,
        ST_INVALID_DT   = 3'd3,
        ST_OVERFLOW     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        BR_SLIDING  = 2'd0,
        BR_POSITIVE = 2'd1,
        BR_NEGATIVE = 2'd2
    } t_branch;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_MUL_A, S_MUL_HH, S_MUL_Q, S_MUL_HL2, S_DECIDE,
        S_BRANCH, S_XI_WAIT, S_CORR_WAIT, S_SQ_START, S_SQ_WAIT, S_ROOT_WAIT,
        S_MUL_T, S_CAP_T, S_FORM, S_CMD_START, S_CMD_WAIT, S_FINISH, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_STATUS, OP_SET_INT, OP_CLEAR,
        OP_MUL_A, OP_MUL_HH, OP_MUL_Q, OP_MUL_HL2, OP_DECIDE,
        OP_DIV_XI, OP_XI_CORR, OP_CAP_CORR,
        OP_MUL_D, OP_SQRT, OP_DIV_ROOT, OP_CAP_ROOT, OP_MUL_T, OP_CAP_T,
        OP_FORM, OP_DIV_CMD, OP_CAP_CMD, OP_COMMIT, OP_OUT
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd    cmd;
        t_status pre_status;
        logic    q_zero;
        logic    sliding;
        logic    ab_ovf;
        logic    fin_ovf;
        logic    div_done;
        logic    sqrt_done;
    } t_dp_stat;

endpackage

@@ hdl/implicit_super_twisting_rate_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// implicit_super_twisting_rate_ctrl
// Per-axis implicit super-twisting rate controller, Q16.16 fixed point.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  -------   ---------------------------  -------------------------------------
//  request   i_in_valid / o_in_stall      cmd, axis, rate, setpoint, step_time,
//                                         new_integral
//  result    o_out_valid / i_out_stall    status, branch, error_out, accel_term,
//                                         command, integral_next,
//                                         virtual_surface, switch_value
//  config    psel/penable/pwrite, pready  gains of axis i at byte address 8*i
//
//  An update waits on the square root and two divisions on the signed branch
//  and on three divisions on the sliding branch; the serial units set its
//  pace. Set and clear requests and ignored commands use no serial unit.
//  Reset is synchronous and active low; it clears gains and integrals.
//  A finished result waits in the output register while the next request is
//  accepted and worked on; it only holds the sequencer if still stalled when
//  the following result is ready.
// ----------------------------------------------------------------------------
module implicit_super_twisting_rate_ctrl #(
    parameter int AXES       = istrc_pkg::AXES_DEF,
    parameter int DATA_WIDTH = istrc_pkg::DATA_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [istrc_pkg::ADDR_W-1:0]       paddr,
    input  logic [istrc_pkg::APB_DW-1:0]       pwdata,
    output logic [istrc_pkg::APB_DW-1:0]       prdata,
    output logic                               pready,
    // request
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_cmd,
    input  logic [1:0]                         i_axis,
    input  logic signed [istrc_pkg::IN_W-1:0]  i_rate,
    input  logic signed [istrc_pkg::IN_W-1:0]  i_setpoint,
    input  logic [istrc_pkg::H_W-1:0]          i_step_time,
    input  logic signed [istrc_pkg::IN_W-1:0]  i_new_integral,
    // result
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [2:0]                         o_status,
    output logic [1:0]                         o_branch,
    output logic signed [istrc_pkg::OUT_W-1:0] o_error_out,
    output logic signed [istrc_pkg::OUT_W-1:0] o_accel_term,
    output logic signed [istrc_pkg::OUT_W-1:0] o_command,
    output logic signed [istrc_pkg::OUT_W-1:0] o_integral_next,
    output logic signed [istrc_pkg::OUT_W-1:0] o_virtual_surface,
    output logic signed [istrc_pkg::XI_W-1:0]  o_switch_value
);
    import istrc_pkg::*;

    t_gain [NCFG-1:0] gains;
    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;

    // gains live in the register file; the datapath latches them per request
    istrc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gains (gains)
    );

    // sequencer: one micro-operation per cycle, waits on the serial units and on a stalled result
    istrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // arithmetic, integral store and result register
    istrc_dp #(
        .AXES       (AXES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .i_gains           (gains),
        .i_cmd_code        (i_cmd),
        .i_axis            (i_axis),
        .i_rate            (i_rate),
        .i_setpoint        (i_setpoint),
        .i_step_time       (i_step_time),
        .i_new_integral    (i_new_integral),
        .o_status          (o_status),
        .o_branch          (o_branch),
        .o_error_out       (o_error_out),
        .o_accel_term      (o_accel_term),
        .o_command         (o_command),
        .o_integral_next   (o_integral_next),
        .o_virtual_surface (o_virtual_surface),
        .o_switch_value    (o_switch_value)
    );

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.op == OP_OUT) |-> !(o_out_valid && i_out_stall))
        else $error("result register loaded while stalled");

    // an accepted request blocks the input until it is done
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not held after accept");

    // a result appears only from a result load
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(dp_cmd.op == OP_OUT))
        else $error("result valid without load");

endmodule

@@ hdl/istrc_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// istrc_regs
// APB-style register file holding the packed gains of each axis.
// ----------------------------------------------------------------------------
module istrc_regs (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [istrc_pkg::ADDR_W-1:0]          paddr,
    input  logic [istrc_pkg::APB_DW-1:0]          pwdata,
    output logic [istrc_pkg::APB_DW-1:0]          prdata,
    output logic                                  pready,
    output istrc_pkg::t_gain [istrc_pkg::NCFG-1:0] o_gains
);
    import istrc_pkg::*;

    t_gain r_gains [NCFG];
    t_reg  sel;
    logic  wr_en;

    assign sel    = t_reg'(paddr[ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCFG; i++) r_gains[i] <= '0;
        end else if (wr_en) begin
            case (sel)
                REG_AXIS0_GAINS: r_gains[0] <= pwdata[GAIN_REG_W-1:0];
                REG_AXIS1_GAINS: r_gains[1] <= pwdata[GAIN_REG_W-1:0];
                REG_AXIS2_GAINS: r_gains[2] <= pwdata[GAIN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_AXIS0_GAINS: prdata = {1'b0, r_gains[0]};
            REG_AXIS1_GAINS: prdata = {1'b0, r_gains[1]};
            REG_AXIS2_GAINS: prdata = {1'b0, r_gains[2]};
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        for (int i = 0; i < NCFG; i++) o_gains[i] = r_gains[i];
    end

endmodule

@@ hdl/istrc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// istrc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module istrc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [istrc_pkg::DVD_W-1:0]   i_dividend,
    input  logic [istrc_pkg::DVS_W-1:0]   i_divisor,
    output logic [istrc_pkg::DVD_W-1:0]   o_quot,
    output logic                          o_done
);
    import istrc_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W:0]   rem_sh;
    logic             q_bit;

    assign rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // quotient bits shift into the dividend register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], q_bit};
            r_rem <= q_bit ? DVS_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[DVS_W-1:0];
        end
    end

    assign o_quot = r_dvd;
    assign o_done = r_done;

endmodule

@@ hdl/istrc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// istrc_ctrl
// Sequencer: walks one request through the datapath micro-operations.
// ----------------------------------------------------------------------------
module istrc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  istrc_pkg::t_dp_stat   i_stat,
    output istrc_pkg::t_dp_cmd    o_cmd
);
    import istrc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept, out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (accept) n_state = S_CHECK;
            S_CHECK: begin
                case (i_stat.cmd)
                    CMD_UPDATE: n_state = (i_stat.pre_status == ST_OK) ? S_MUL_A : S_OUT;
                    CMD_SET:    n_state = S_OUT;
                    CMD_CLEAR:  n_state = S_OUT;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_MUL_A:     n_state = S_MUL_HH;
            S_MUL_HH:    n_state = S_MUL_Q;
            S_MUL_Q:     n_state = S_MUL_HL2;
            S_MUL_HL2:   n_state = S_DECIDE;
            S_DECIDE:    n_state = S_BRANCH;
            S_BRANCH: begin
                if (i_stat.q_zero)       n_state = S_OUT;
                else if (i_stat.sliding) n_state = S_XI_WAIT;
                else                     n_state = S_SQ_START;
            end
            S_XI_WAIT:   if (i_stat.div_done) n_state = S_CORR_WAIT;
            S_CORR_WAIT: if (i_stat.div_done) n_state = S_FORM;
            S_SQ_START:  n_state = S_SQ_WAIT;
            S_SQ_WAIT:   if (i_stat.sqrt_done) n_state = S_ROOT_WAIT;
            S_ROOT_WAIT: if (i_stat.div_done) n_state = S_MUL_T;
            S_MUL_T:     n_state = S_CAP_T;
            S_CAP_T:     n_state = S_FORM;
            S_FORM:      n_state = S_CMD_START;
            S_CMD_START: n_state = i_stat.ab_ovf ? S_OUT : S_CMD_WAIT;
            S_CMD_WAIT:  if (i_stat.div_done) n_state = S_FINISH;
            S_FINISH:    n_state = S_OUT;
            S_OUT:       if (out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op     = OP_NONE;
        o_cmd.status = ST_OVERFLOW;
        case (r_state)
            S_IDLE:      if (accept) o_cmd.op = OP_LOAD;
            S_CHECK: begin
                case (i_stat.cmd)
                    CMD_UPDATE: begin
                        if (i_stat.pre_status != ST_OK) o_cmd.op = OP_STATUS;
                        o_cmd.status = i_stat.pre_status;
                    end
                    CMD_SET: begin
                        o_cmd.op     = (i_stat.pre_status == ST_OK) ? OP_SET_INT : OP_STATUS;
                        o_cmd.status = i_stat.pre_status;
                    end
                    CMD_CLEAR:  o_cmd.op = OP_CLEAR;
                    default:    o_cmd.op = OP_NONE;
                endcase
            end
            S_MUL_A:     o_cmd.op = OP_MUL_A;
            S_MUL_HH:    o_cmd.op = OP_MUL_HH;
            S_MUL_Q:     o_cmd.op = OP_MUL_Q;
            S_MUL_HL2:   o_cmd.op = OP_MUL_HL2;
            S_DECIDE:    o_cmd.op = OP_DECIDE;
            S_BRANCH: begin
                if (i_stat.q_zero)       o_cmd.op = OP_STATUS;
                else if (i_stat.sliding) o_cmd.op = OP_DIV_XI;
                else                     o_cmd.op = OP_MUL_D;
            end
            S_XI_WAIT:   if (i_stat.div_done) o_cmd.op = OP_XI_CORR;
            S_CORR_WAIT: if (i_stat.div_done) o_cmd.op = OP_CAP_CORR;
            S_SQ_START:  o_cmd.op = OP_SQRT;
            S_SQ_WAIT:   if (i_stat.sqrt_done) o_cmd.op = OP_DIV_ROOT;
            S_ROOT_WAIT: if (i_stat.div_done) o_cmd.op = OP_CAP_ROOT;
            S_MUL_T:     o_cmd.op = OP_MUL_T;
            S_CAP_T:     o_cmd.op = OP_CAP_T;
            S_FORM:      o_cmd.op = OP_FORM;
            S_CMD_START: o_cmd.op = i_stat.ab_ovf ? OP_STATUS : OP_DIV_CMD;
            S_CMD_WAIT:  if (i_stat.div_done) o_cmd.op = OP_CAP_CMD;
            S_FINISH:    o_cmd.op = i_stat.fin_ovf ? OP_STATUS : OP_COMMIT;
            S_OUT:       if (out_free) o_cmd.op = OP_OUT;
            default:     o_cmd.op = OP_NONE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == S_OUT && out_free) n_out_valid = 1'b1;
        else if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hdl/istrc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// istrc_dp
// Datapath: operand registers, shared multiplier, serial square root,
// divider, integral store and result register.
// ----------------------------------------------------------------------------
module istrc_dp #(
    parameter int AXES       = istrc_pkg::AXES_DEF,
    parameter int DATA_WIDTH = istrc_pkg::DATA_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  istrc_pkg::t_dp_cmd                     i_cmd,
    output istrc_pkg::t_dp_stat                    o_stat,
    input  istrc_pkg::t_gain [istrc_pkg::NCFG-1:0] i_gains,
    input  logic [1:0]                             i_cmd_code,
    input  logic [1:0]                             i_axis,
    input  logic signed [istrc_pkg::IN_W-1:0]      i_rate,
    input  logic signed [istrc_pkg::IN_W-1:0]      i_setpoint,
    input  logic [istrc_pkg::H_W-1:0]              i_step_time,
    input  logic signed [istrc_pkg::IN_W-1:0]      i_new_integral,
    output logic [2:0]                             o_status,
    output logic [1:0]                             o_branch,
    output logic signed [istrc_pkg::OUT_W-1:0]     o_error_out,
    output logic signed [istrc_pkg::OUT_W-1:0]     o_accel_term,
    output logic signed [istrc_pkg::OUT_W-1:0]     o_command,
    output logic signed [istrc_pkg::OUT_W-1:0]     o_integral_next,
    output logic signed [istrc_pkg::OUT_W-1:0]     o_virtual_surface,
    output logic signed [istrc_pkg::XI_W-1:0]      o_switch_value
);
    import istrc_pkg::*;

    localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;
    localparam logic signed [63:0] LIM = 64'sd1 <<< (DATA_WIDTH - 1);

    function automatic logic fits(input logic signed [63:0] v);
        return (v >= -LIM) && (v < LIM);
    endfunction

    // latched request
    t_cmd              r_cmd;
    logic [1:0]        r_axis;
    logic signed [32:0] r_s;
    logic [H_W-1:0]    r_h;
    logic [GAIN_W-1:0] r_l1, r_l2, r_g;
    logic signed [63:0] r_nu;
    logic signed [63:0] r_newint;
    t_status           r_status;

    // working registers
    logic [63:0]       r_prod;
    logic [26:0]       r_a16;
    logic [DVS_W-1:0]  r_q;
    logic [26:0]       r_cm;
    logic [48:0]       r_delta;
    logic              r_sliding;
    logic [16:0]       r_xi;
    logic [56:0]       r_corr;
    logic [31:0]       r_root;
    logic [47:0]       r_zm;
    logic [53:0]       r_tm;
    logic signed [63:0] r_next, r_a;
    logic [63:0]       r_cmdq;

    logic signed [DATA_WIDTH-1:0] r_int [AXES];

    // divider operands
    logic [DVD_W-1:0] div_dvd, div_quot;
    logic [DVS_W-1:0] div_dvs;
    logic             div_start, div_done;
    logic [63:0]      am;

    // square root state
    localparam int SQ_CNT_W = $clog2(SQ_W);

    logic [SQ_IN_W-1:0]  r_sq_x;
    logic [SQ_W+1:0]     r_sq_rem;
    logic [SQ_W-1:0]     r_sq_root;
    logic [SQ_CNT_W-1:0] r_sq_cnt;
    logic                r_sq_busy, r_sq_done;
    logic [SQ_W+1:0]     sq_sh, sq_trial;
    logic                sq_ge;
    logic [SQ_IN_W-1:0]  sq_in;

    // request decode
    logic [AX_W-1:0]   in_idx, ridx;
    logic              axis_ok, in_axis_ok;
    t_gain             in_gain;
    logic [32:0]       abs_s;
    logic [48:0]       s32;
    logic              neg;
    t_status           pre;

    assign in_idx     = i_axis[AX_W-1:0];
    assign ridx       = r_axis[AX_W-1:0];
    assign in_axis_ok = (int'(i_axis) < AXES);
    assign axis_ok    = (int'(r_axis) < AXES);
    assign in_gain    = (int'(i_axis) < NCFG) ? i_gains[i_axis] : '0;
    assign neg        = r_s[32];
    assign abs_s      = neg ? 33'(-r_s) : 33'(r_s);
    assign s32        = {abs_s, 16'b0};

    always_comb begin
        if (r_cmd == CMD_SET) pre = axis_ok ? ST_OK : ST_INVALID_AXIS;
        else if (!axis_ok) pre = ST_INVALID_AXIS;
        else if (r_l1 == '0 || r_l2 == '0 || r_g == '0) pre = ST_NOT_CONF;
        else if (r_h == '0) pre = ST_INVALID_DT;
        else if (!fits({{31{r_s[32]}}, r_s})) pre = ST_OVERFLOW;
        else pre = ST_OK;
    end

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic        mul_en;

    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (i_cmd.op)
            OP_MUL_A:    begin mul_a = 32'(r_h);  mul_b = 32'(r_l1); end
            OP_MUL_HH:   begin mul_a = 32'(r_h);  mul_b = 32'(r_h);  end
            OP_MUL_Q:    begin mul_a = r_prod[47:16]; mul_b = 32'(r_l2); end
            OP_MUL_HL2:  begin mul_a = 32'(r_h);  mul_b = 32'(r_l2); end
            OP_MUL_D:    begin mul_a = 32'(r_a16); mul_b = 32'(r_a16); end
            OP_CAP_ROOT: begin mul_a = div_quot[31:0]; mul_b = div_quot[31:0]; end
            OP_MUL_T:    begin mul_a = 32'(r_l1); mul_b = r_root; end
            default:     mul_en = 1'b0;
        endcase
    end

    assign am = r_a[63] ? 64'(-r_a) : 64'(r_a);

    always_comb begin
        div_start = 1'b1;
        div_dvd   = '0;
        div_dvs   = '0;
        case (i_cmd.op)
            OP_DIV_XI: begin
                div_dvd = {s32[47:0], 16'b0};
                div_dvs = r_q;
            end
            OP_XI_CORR: begin
                div_dvd = {7'b0, abs_s, 24'b0};
                div_dvs = DVS_W'(r_h);
            end
            OP_DIV_ROOT: begin
                div_dvd = 64'({r_delta, 1'b0});
                div_dvs = DVS_W'(r_sq_root) + DVS_W'(r_a16);
            end
            OP_DIV_CMD: begin
                div_dvd = {am[53:0], 10'b0};
                div_dvs = DVS_W'(r_g);
            end
            default: div_start = 1'b0;
        endcase
    end

    istrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_quot     (div_quot),
        .o_done     (div_done)
    );

    // serial square root, two radicand bits per cycle
    assign sq_in    = SQ_IN_W'(r_prod[53:0]) + SQ_IN_W'({r_delta, 2'b00});
    assign sq_sh    = {r_sq_rem[SQ_W-1:0], r_sq_x[SQ_IN_W-1 -: 2]};
    assign sq_trial = {r_sq_root, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
            r_sq_done <= 1'b0;
            r_sq_cnt  <= '0;
        end else begin
            r_sq_done <= 1'b0;
            if (i_cmd.op == OP_SQRT) begin
                r_sq_busy <= 1'b1;
                r_sq_cnt  <= '0;
            end else if (r_sq_busy) begin
                r_sq_cnt <= r_sq_cnt + 1'b1;
                if (r_sq_cnt == SQ_CNT_W'(SQ_W - 1)) begin
                    r_sq_busy <= 1'b0;
                    r_sq_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SQRT) begin
            r_sq_x    <= sq_in;
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end else if (r_sq_busy) begin
            r_sq_x    <= {r_sq_x[SQ_IN_W-3:0], 2'b00};
            r_sq_rem  <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
            r_sq_root <= {r_sq_root[SQ_W-2:0], sq_ge};
        end
    end

    // result formation
    logic signed [63:0] corr_s, cm64, ma64, f_next, f_a, cmdv, z_val, nv;
    logic signed [XI_W-1:0] xi_val;

    always_comb begin
        corr_s = neg ? -$signed({7'b0, r_corr}) : $signed({7'b0, r_corr});
        cm64   = $signed({37'b0, r_cm});
        ma64   = (cm64 <<< 1) + $signed({10'b0, r_tm});
        if (r_sliding) begin
            f_next = r_nu - corr_s;
            f_a    = r_nu - (corr_s <<< 1);
        end else begin
            f_next = neg ? (r_nu + cm64) : (r_nu - cm64);
            f_a    = neg ? (r_nu + ma64) : (r_nu - ma64);
        end
        cmdv = r_a[63] ? -$signed(r_cmdq) : $signed(r_cmdq);
        if (r_sliding) z_val = '0;
        else z_val = neg ? -$signed({16'b0, r_zm}) : $signed({16'b0, r_zm});
        if (r_sliding) xi_val = neg ? -$signed({1'b0, r_xi}) : $signed({1'b0, r_xi});
        else xi_val = neg ? -XI_W'(ONE_Q16) : XI_W'(ONE_Q16);
        if (r_newint < -LIM) nv = -LIM;
        else if (r_newint >= LIM) nv = LIM - 64'sd1;
        else nv = r_newint;
    end

    // request and working registers
    always_ff @(posedge i_clk) begin
        if (mul_en) r_prod <= 64'(mul_a) * 64'(mul_b);
        case (i_cmd.op)
            OP_LOAD: begin
                r_cmd    <= t_cmd'(i_cmd_code);
                r_axis   <= i_axis;
                r_s      <= 33'(i_rate) - 33'(i_setpoint);
                r_h      <= i_step_time;
                r_l1     <= in_gain[L1_LSB +: GAIN_W];
                r_l2     <= in_gain[L2_LSB +: GAIN_W];
                r_g      <= in_gain[G_LSB +: GAIN_W];
                r_nu     <= in_axis_ok ? 64'(r_int[in_idx]) : '0;
                r_newint <= 64'(i_new_integral);
                r_status <= ST_OK;
            end
            OP_STATUS:   r_status <= i_cmd.status;
            OP_SET_INT:  r_next <= nv;
            OP_MUL_HH:   r_a16 <= r_prod[44:18];
            OP_MUL_HL2:  r_q <= r_prod[52:10];
            OP_DECIDE: begin
                r_cm      <= r_prod[44:18];
                r_delta   <= s32 - 49'(r_q);
                r_sliding <= (s32 <= 49'(r_q));
            end
            OP_XI_CORR:  r_xi <= div_quot[16:0];
            OP_CAP_CORR: r_corr <= div_quot[56:0];
            OP_CAP_ROOT: r_root <= div_quot[31:0];
            OP_MUL_T:    r_zm <= r_prod[63:16];
            OP_CAP_T:    r_tm <= r_prod[63:10];
            OP_FORM: begin
                r_next <= f_next;
                r_a    <= f_a;
            end
            OP_CAP_CMD:  r_cmdq <= div_quot;
            default: ;
        endcase
    end

    // integral store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) r_int[i] <= '0;
        end else begin
            case (i_cmd.op)
                OP_SET_INT: r_int[ridx] <= nv[DATA_WIDTH-1:0];
                OP_COMMIT:  r_int[ridx] <= r_next[DATA_WIDTH-1:0];
                OP_CLEAR:   for (int i = 0; i < AXES; i++) r_int[i] <= '0;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            o_status          <= r_status;
            o_branch          <= BR_SLIDING;
            o_error_out       <= '0;
            o_accel_term      <= '0;
            o_command         <= '0;
            o_integral_next   <= '0;
            o_virtual_surface <= '0;
            o_switch_value    <= '0;
            if (r_status == ST_OK && r_cmd == CMD_SET) begin
                o_integral_next <= r_next[OUT_W-1:0];
            end else if (r_status == ST_OK && r_cmd == CMD_UPDATE) begin
                o_branch          <= r_sliding ? BR_SLIDING :
                                     (neg ? BR_NEGATIVE : BR_POSITIVE);
                o_error_out       <= r_s[OUT_W-1:0];
                o_accel_term      <= r_a[OUT_W-1:0];
                o_command         <= cmdv[OUT_W-1:0];
                o_integral_next   <= r_next[OUT_W-1:0];
                o_virtual_surface <= z_val[OUT_W-1:0];
                o_switch_value    <= xi_val;
            end
        end
    end

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.pre_status = pre;
        o_stat.q_zero     = (r_q == '0);
        o_stat.sliding    = r_sliding;
        o_stat.ab_ovf     = !fits(r_next) || !fits(r_a);
        o_stat.fin_ovf    = !fits(cmdv) || !fits(z_val);
        o_stat.div_done   = div_done;
        o_stat.sqrt_done  = r_sq_done;
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the implicit super-twisting rate controller.
// Gains are written over the APB port and read back; update, set-integral,
// clear and ignored requests are sent, mostly in bursts with random gaps,
// while the result side stalls on its own pattern. A behavioural model of the
// controller predicts every result, and a checker compares each one field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import istrc_pkg::*;

    localparam int NAX = 3;

    // one request as sent on the input channel
    typedef struct packed {
        t_cmd        c;
        logic [1:0]  ax;
        logic [31:0] rt;
        logic [31:0] sp;
        logic [23:0] h;
        logic [31:0] ni;
    } req_t;

    // one result as the controller should report it
    typedef struct packed {
        logic [2:0]  st;
        logic [1:0]  br;
        logic [31:0] err;
        logic [31:0] acc;
        logic [31:0] cmdv;
        logic [31:0] nxt;
        logic [31:0] vs;
        logic [17:0] xi;
    } res_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_cmd = '0, i_axis = '0;
    logic signed [31:0] i_rate = '0, i_setpoint = '0, i_new_integral = '0;
    logic [23:0] i_step_time = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic [1:0]  o_branch;
    logic signed [31:0] o_error_out, o_accel_term, o_command, o_integral_next;
    logic signed [31:0] o_virtual_surface;
    logic signed [17:0] o_switch_value;

    // controller model state
    t_gain        gain_reg [NAX];
    longint       integ    [NAX];
    res_t         pending_res [$];

    int err_cnt, n_res, n_slide, n_pos, n_neg, n_fault;
    int stall_mode;     // 0 never, 1 light, 2 heavy, 3 periodic
    int hold_req;       // long receiver hold-off, in cycles
    int hold_cnt, pat_cnt;
    int burst_left;
    bit pace_gaps;

    implicit_super_twisting_rate_ctrl u_top (.*);

    always #10 i_clk = ~i_clk;

    initial begin
        #60_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Controller model
    // ------------------------------------------------------------------------
    function automatic longint unsigned sqrt_floor(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit fits32(input longint v);
        return v >= -(64'sd1 <<< 31) && v < (64'sd1 <<< 31);
    endfunction

    // works out the result of one request and advances the integrals
    function automatic bit rate_ctrl_step(input req_t q, output res_t r);
        longint unsigned l1, l2, gg, hh, abs_s, s32, alpha32, q32, delta, a16, root, am;
        longint s, nu, nxt, a, z, xi, cmdv, corr, cm, tm, sg;
        t_branch br;
        r = '0;
        case (q.c)
            CMD_IGNORE: return 0;
            CMD_CLEAR: begin
                for (int i = 0; i < NAX; i++) integ[i] = 0;
                return 1;
            end
            CMD_SET: begin
                if (q.ax >= NAX) begin
                    r.st = ST_INVALID_AXIS;
                end else begin
                    integ[q.ax] = longint'($signed(q.ni));
                    r.nxt = q.ni;
                end
                return 1;
            end
            default: ;
        endcase
        if (q.ax >= NAX) begin
            r.st = ST_INVALID_AXIS;
            return 1;
        end
        l1 = gain_reg[q.ax][L1_LSB +: GAIN_W];
        l2 = gain_reg[q.ax][L2_LSB +: GAIN_W];
        gg = gain_reg[q.ax][G_LSB +: GAIN_W];
        hh = q.h;
        if (l1 == 0 || l2 == 0 || gg == 0) begin
            r.st = ST_NOT_CONF;
            return 1;
        end
        if (hh == 0) begin
            r.st = ST_INVALID_DT;
            return 1;
        end
        s = longint'($signed(q.rt)) - longint'($signed(q.sp));
        r.st = ST_OVERFLOW;
        if (!fits32(s)) return 1;
        abs_s = (s < 0) ? longint'(-s) : s;
        s32 = abs_s << 16;
        alpha32 = (hh * l1) >> 2;
        q32 = (((hh * hh) >> 16) * l2) >> 10;
        if (q32 == 0) return 1;
        nu = integ[q.ax];
        if (s32 <= q32) begin
            // inside the boundary layer: proportional switch, surface held at zero
            br = BR_SLIDING;
            xi = (s32 << 16) / q32;
            corr = (abs_s << 24) / hh;
            if (s < 0) begin
                xi = -xi;
                corr = -corr;
            end
            nxt = nu - corr;
            a = nu - 2 * corr;
            z = 0;
        end else begin
            // outside: rationalised root of r^2 + alpha*r = |s| - q
            delta = s32 - q32;
            a16 = alpha32 >> 16;
            root = (2 * delta) / (sqrt_floor(a16 * a16 + 4 * delta) + a16);
            cm = (hh * l2) >> 18;
            tm = (l1 * root) >> 10;
            sg = (s < 0) ? -1 : 1;
            br = (s < 0) ? BR_NEGATIVE : BR_POSITIVE;
            xi = sg * ONE_Q16;
            z = sg * longint'((root * root) >> 16);
            nxt = nu - sg * cm;
            a = nu - sg * (2 * cm + tm);
        end
        if (!fits32(nxt) || !fits32(a)) return 1;
        am = (a < 0) ? longint'(-a) : a;
        cmdv = (am << 10) / gg;
        if (a < 0) cmdv = -cmdv;
        if (!fits32(cmdv) || !fits32(z)) return 1;
        integ[q.ax] = nxt;
        r.st = ST_OK;
        r.br = br;
        r.err = s[31:0];
        r.acc = a[31:0];
        r.cmdv = cmdv[31:0];
        r.nxt = nxt[31:0];
        r.vs = z[31:0];
        r.xi = xi[17:0];
        return 1;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: stall pattern and checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            pat_cnt <= pat_cnt + 1;
            if (hold_req > 0) begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    1: i_out_stall <= ($urandom_range(0, 5) == 0);
                    2: i_out_stall <= ($urandom_range(0, 2) != 0);
                    3: i_out_stall <= (pat_cnt % 7 < 3);
                    default: i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
        err_cnt++;
    endtask

    // outputs and stall are steady at the falling edge; the result is taken
    // at the following rising edge
    always @(negedge i_clk) begin
        res_t w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_res.size() == 0) begin
                report("unexpected result", o_status, 0);
            end else begin
                w = pending_res.pop_front();
                n_res++;
                if (o_status != w.st) report("status", o_status, w.st);
                if (o_branch != w.br) report("branch", o_branch, w.br);
                if (o_error_out != w.err) report("error_out", o_error_out, w.err);
                if (o_accel_term != w.acc) report("accel_term", o_accel_term, w.acc);
                if (o_command != w.cmdv) report("command", o_command, w.cmdv);
                if (o_integral_next != w.nxt)
                    report("integral_next", o_integral_next, w.nxt);
                if (o_virtual_surface != w.vs)
                    report("virtual_surface", o_virtual_surface, w.vs);
                if (o_switch_value != w.xi) report("switch_value", o_switch_value, w.xi);
                if (w.st != ST_OK) n_fault++;
                else if (w.br == BR_POSITIVE) n_pos++;
                else if (w.br == BR_NEGATIVE) n_neg++;
                else if (w.vs == 0 && w.err != 0) n_slide++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic send_req(input req_t q);
        bit   took;
        res_t r;
        i_cmd <= q.c;
        i_axis <= q.ax;
        i_rate <= q.rt;
        i_setpoint <= q.sp;
        i_step_time <= q.h;
        i_new_integral <= q.ni;
        i_in_valid <= 1'b1;
        do begin
            @(negedge i_clk);
            took = !o_in_stall;
            @(posedge i_clk);
        end while (!took);
        if (rate_ctrl_step(q, r)) pending_res.push_back(r);
        // bursts of random length, random gaps between them
        if (pace_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 15);
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    endtask

    task automatic go_idle();
        i_in_valid <= 1'b0;
        wait (pending_res.size() == 0);
        // an ignored command may still be in flight
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_gains(input t_reg idx, input t_gain v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(8 * idx);
        pwdata <= APB_DW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        gain_reg[idx] = v;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata[GAIN_REG_W-1:0] !== v) report("gain readback", prdata, v);
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_gain pack_gains(input int l1, input int l2, input int g);
        return {GAIN_W'(g), GAIN_W'(l2), GAIN_W'(l1)};
    endfunction

    function automatic req_t mk(input t_cmd c, input int ax, input int rt, input int sp,
                                input int h, input int ni);
        return '{c, ax[1:0], rt, sp, h[23:0], ni};
    endfunction

    function automatic req_t rand_req();
        req_t q;
        int   k, pick;
        q.rt = $urandom;
        q.sp = $urandom;
        q.ni = $urandom;
        q.h = $urandom;
        q.ax = ($urandom_range(0, 11) == 0) ? 2'd3 : 2'($urandom_range(0, NAX - 1));
        pick = $urandom_range(0, 99);
        if (pick < 82) q.c = CMD_UPDATE;
        else if (pick < 92) q.c = CMD_SET;
        else if (pick < 96) q.c = CMD_CLEAR;
        else q.c = CMD_IGNORE;
        // mostly plausible steps and errors near the switching threshold
        pick = $urandom_range(0, 99);
        if (pick < 3) q.h = '0;
        else if (pick < 70) q.h = 24'($urandom_range(1, 1 << $urandom_range(10, 24)));
        if ($urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, 24);
            q.sp = $signed(32'($urandom)) >>> $urandom_range(4, 16);
            q.rt = q.sp + ($signed(32'($urandom)) >>> (31 - k));
        end
        if ($urandom_range(0, 1)) q.ni = $signed(q.ni) >>> $urandom_range(6, 20);
        return q;
    endfunction

    function automatic t_gain rand_gains();
        t_gain v;
        v = {$urandom, $urandom};
        // keep most magnitudes moderate so results stay in range
        v[L1_LSB +: GAIN_W] = 21'($urandom_range(1, 1 << $urandom_range(4, 21)));
        v[L2_LSB +: GAIN_W] = 21'($urandom_range(1, 1 << $urandom_range(4, 21)));
        v[G_LSB +: GAIN_W] = 21'($urandom_range(1, 1 << $urandom_range(4, 21)));
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        stall_mode = 0;
        pace_gaps = 0;
        // axis 2 left unconfigured
        write_gains(REG_AXIS0_GAINS, pack_gains(2048, 4096, 1024));
        write_gains(REG_AXIS1_GAINS, pack_gains(21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF));
        send_req(mk(CMD_UPDATE, 2, 65536, 0, 167772, 0));         // unconfigured
        send_req(mk(CMD_UPDATE, 3, 65536, 0, 167772, 0));         // bad axis
        send_req(mk(CMD_SET, 3, 0, 0, 0, 5));                     // bad axis on set
        send_req(mk(CMD_UPDATE, 0, 65536, 0, 0, 0));              // zero step
        send_req(mk(CMD_UPDATE, 0, 65536, 0, 1, 0));              // q truncates to zero
        send_req(mk(CMD_UPDATE, 0, 32'h7FFFFFFF, 32'h80000000, 167772, 0)); // error overflow
        send_req(mk(CMD_UPDATE, 0, 5, 0, 167772, 0));             // sliding, positive s
        send_req(mk(CMD_UPDATE, 0, -5, 0, 167772, 0));            // sliding, negative s
        send_req(mk(CMD_UPDATE, 0, 0, 0, 167772, 0));             // zero error
        send_req(mk(CMD_UPDATE, 0, 65536, 0, 167772, 0));         // positive branch
        send_req(mk(CMD_UPDATE, 0, 0, 65536, 167772, 0));         // negative branch
        send_req(mk(CMD_UPDATE, 1, 32'h7FFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 0));
        send_req(mk(CMD_UPDATE, 1, 32'h80000000, 0, 24'hFFFFFF, 0));
        send_req(mk(CMD_SET, 0, 0, 0, 0, 32'h7FFFFFFF));          // integral at maximum
        send_req(mk(CMD_UPDATE, 0, -5, 0, 167772, 0));            // a overflows
        send_req(mk(CMD_SET, 1, 0, 0, 0, 32'h80000000));          // integral at minimum
        send_req(mk(CMD_UPDATE, 1, 65536, 0, 24'hFFFFFF, 0));     // a overflows low
        send_req(mk(CMD_IGNORE, 0, 1, 2, 3, 4));                  // no result
        send_req(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
        send_req(mk(CMD_UPDATE, 0, 65536, 0, 167772, 0));
        send_req(mk(CMD_UPDATE, 1, 1, 0, 24'h000100, 0));
        go_idle();
    endtask

    task automatic test_random(input int n, input int smode, input bit gaps);
        stall_mode = smode;
        pace_gaps = gaps;
        for (int i = 0; i < n; i++) send_req(rand_req());
        go_idle();
    endtask

    task automatic test_gain_settings();
        write_gains(REG_AXIS0_GAINS, rand_gains());
        write_gains(REG_AXIS1_GAINS, rand_gains());
        write_gains(REG_AXIS2_GAINS, rand_gains());
        test_random(260, 1, 1);
        // extremes: smallest, largest, one field zero
        write_gains(REG_AXIS0_GAINS, pack_gains(1, 1, 1));
        write_gains(REG_AXIS1_GAINS, {GAIN_REG_W{1'b1}});
        write_gains(REG_AXIS2_GAINS, pack_gains(3000, 0, 1024));
        test_random(220, 3, 1);
        write_gains(REG_AXIS0_GAINS, {$urandom, $urandom});
        write_gains(REG_AXIS1_GAINS, pack_gains(0, 5000, 1024));
        write_gains(REG_AXIS2_GAINS, rand_gains());
        test_random(200, 2, 1);
        write_gains(REG_AXIS0_GAINS, rand_gains());
        write_gains(REG_AXIS1_GAINS, rand_gains());
        write_gains(REG_AXIS2_GAINS, pack_gains(2048, 4096, 0));
        test_random(220, 0, 0);
        write_gains(REG_AXIS2_GAINS, rand_gains());
        test_random(260, 1, 1);
    endtask

    task automatic test_backpressure();
        stall_mode = 1;
        pace_gaps = 0;
        // receiver holds off while requests keep coming, so the input stalls
        hold_req = 900;
        for (int i = 0; i < 12; i++) send_req(rand_req());
        // then the sender waits until everything has drained
        i_in_valid <= 1'b0;
        wait (pending_res.size() == 0);
        @(posedge i_clk);
        pace_gaps = 1;
        for (int i = 0; i < 150; i++) send_req(rand_req());
        go_idle();
    endtask

    initial begin
        for (int i = 0; i < NAX; i++) begin
            gain_reg[i] = '0;
            integ[i] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_gain_settings();
        test_backpressure();

        repeat (250) @(posedge i_clk);
        $display("checked %0d results: %0d sliding, %0d positive, %0d negative, %0d errors",
                 n_res, n_slide, n_pos, n_neg, n_fault);
        $display("gain sets incl. extremes and unconfigured fields, long receiver hold-off");
        if (err_cnt == 0 && pending_res.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
